@@ rtl/csfe_pkg.sv @@
// Shared types, constants and helpers for the clipped shape fill engine.
// Used by the front end, the raster back end and the top level.
package csfe_pkg;

  localparam int StoreWidth  = 240;
  localparam int StoreHeight = 135;
  localparam int StoreDepth  = StoreWidth * StoreHeight;
  localparam int AddrW       = $clog2(StoreDepth);
  localparam int ColW        = $clog2(StoreWidth + 1);
  localparam int RowW        = $clog2(StoreHeight + 1);
  localparam int QueueDepth  = 4;
  localparam int QueuePtrW   = $clog2(QueueDepth);

  localparam logic [2:0] KIND_CLEAR   = 3'd0;
  localparam logic [2:0] KIND_RECT    = 3'd1;
  localparam logic [2:0] KIND_CIRCLE  = 3'd2;
  localparam logic [2:0] KIND_ELLIPSE = 3'd3;
  localparam logic [2:0] KIND_READ    = 3'd4;

  localparam logic [7:0] RedMask   = 8'hf8;
  localparam logic [7:0] GreenMask = 8'hfc;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'b001,
    OP_FILL  = 3'b010,
    OP_READ  = 3'b100
  } op_t;

  // One classified command: a box to walk, shape weights, color.
  typedef struct packed {
    op_t               op;
    logic              shaped;
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic [ColW-1:0]   x0;
    logic [ColW-1:0]   x1;
    logic [RowW-1:0]   y0;
    logic [RowW-1:0]   y1;
    logic [15:0]       wx;
    logic [15:0]       wy;
    logic [31:0]       lim;
    logic [15:0]       color;
    logic              on_store;
  } cmd_t;

  function automatic logic [15:0] pack_color(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    logic [15:0] v;
    v = {r[7:3], g[7:2], b[7:3]};
    return {v[7:0], v[15:8]};
  endfunction

endpackage

@@ rtl/csfe_front.sv @@
// Front end: accepts commands, clips boxes and derives shape weights.
// Depends on csfe_pkg; feeds the command queue in the top level.
module csfe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           kind,
  input  logic signed [9:0]    x_pos,
  input  logic signed [9:0]    y_pos,
  input  logic [7:0]           size_a,
  input  logic [7:0]           size_b,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output csfe_pkg::cmd_t       cmd
);

  // Stage 1 registers the raw item and squares; stage 2 forms the limit.
  logic               s1_valid_r, s1_valid_nxt;
  logic [2:0]         s1_kind_r;
  logic signed [10:0] s1_x_r, s1_y_r;
  logic [7:0]         s1_a_r, s1_b_r;
  logic [15:0]        s1_a2_r, s1_b2_r, s1_color_r;
  logic               s2_valid_r, s2_valid_nxt;
  csfe_pkg::cmd_t     s2_cmd_r, s2_cmd_nxt;
  logic               s2_keep;

  logic signed [11:0] lo_x, hi_x, lo_y, hi_y;
  logic               accept1, adv2;

  assign adv2     = !s2_valid_r || cmd_ready;
  assign in_ready = !s1_valid_r || adv2;
  assign accept1  = in_valid && in_ready;
  assign cmd_valid = s2_valid_r;
  assign cmd       = s2_cmd_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (adv2) s1_valid_nxt = 1'b0;
    if (accept1) s1_valid_nxt = 1'b1;
    s2_valid_nxt = s2_valid_r;
    if (cmd_ready) s2_valid_nxt = 1'b0;
    if (adv2 && s1_valid_r) s2_valid_nxt = s2_keep;
  end

  always_comb begin
    s2_cmd_nxt = '0;
    s2_keep    = 1'b0;
    s2_cmd_nxt.color = s1_color_r;
    s2_cmd_nxt.cx    = s1_x_r;
    s2_cmd_nxt.cy    = s1_y_r;
    s2_cmd_nxt.op    = csfe_pkg::OP_FILL;
    lo_x = 12'(s1_x_r);
    lo_y = 12'(s1_y_r);
    hi_x = 12'(s1_x_r) + 12'(s1_a_r);
    hi_y = 12'(s1_y_r) + 12'(s1_b_r);
    unique case (s1_kind_r)
      csfe_pkg::KIND_CLEAR: begin
        s2_keep = 1'b1;
        s2_cmd_nxt.op = csfe_pkg::OP_CLEAR;
      end
      csfe_pkg::KIND_RECT: s2_keep = 1'b1;
      csfe_pkg::KIND_CIRCLE: begin
        s2_keep = 1'b1;
        s2_cmd_nxt.shaped = 1'b1;
        lo_x = 12'(s1_x_r) - 12'(s1_a_r);
        lo_y = 12'(s1_y_r) - 12'(s1_a_r);
        hi_x = 12'(s1_x_r) + 12'(s1_a_r) + 12'sd1;
        hi_y = 12'(s1_y_r) + 12'(s1_a_r) + 12'sd1;
        s2_cmd_nxt.wx  = 16'd1;
        s2_cmd_nxt.wy  = 16'd1;
        s2_cmd_nxt.lim = 32'(s1_a2_r);
      end
      csfe_pkg::KIND_ELLIPSE: begin
        s2_keep = (s1_a_r != 8'd0) && (s1_b_r != 8'd0);
        s2_cmd_nxt.shaped = 1'b1;
        lo_x = 12'(s1_x_r) - 12'(s1_a_r);
        lo_y = 12'(s1_y_r) - 12'(s1_b_r);
        hi_x = 12'(s1_x_r) + 12'(s1_a_r) + 12'sd1;
        hi_y = 12'(s1_y_r) + 12'(s1_b_r) + 12'sd1;
        s2_cmd_nxt.wx  = s1_b2_r;
        s2_cmd_nxt.wy  = s1_a2_r;
        s2_cmd_nxt.lim = 32'(s1_a2_r) * 32'(s1_b2_r);
      end
      csfe_pkg::KIND_READ: begin
        s2_keep = 1'b1;
        s2_cmd_nxt.op = csfe_pkg::OP_READ;
        s2_cmd_nxt.on_store = (s1_x_r >= 0) && (s1_y_r >= 0) &&
                              (s1_x_r < 11'(csfe_pkg::StoreWidth)) &&
                              (s1_y_r < 11'(csfe_pkg::StoreHeight));
        lo_x = 12'(s1_x_r);
        lo_y = 12'(s1_y_r);
      end
      default: s2_keep = 1'b0;
    endcase
    if (lo_x < 0) lo_x = '0;
    if (lo_y < 0) lo_y = '0;
    if (hi_x > 12'(csfe_pkg::StoreWidth)) hi_x = 12'(csfe_pkg::StoreWidth);
    if (hi_y > 12'(csfe_pkg::StoreHeight)) hi_y = 12'(csfe_pkg::StoreHeight);
    if (lo_x > 12'(csfe_pkg::StoreWidth)) lo_x = 12'(csfe_pkg::StoreWidth);
    if (lo_y > 12'(csfe_pkg::StoreHeight)) lo_y = 12'(csfe_pkg::StoreHeight);
    if (hi_x < lo_x) hi_x = lo_x;
    if (hi_y < lo_y) hi_y = lo_y;
    s2_cmd_nxt.x0 = lo_x[csfe_pkg::ColW-1:0];
    s2_cmd_nxt.y0 = lo_y[csfe_pkg::RowW-1:0];
    s2_cmd_nxt.x1 = hi_x[csfe_pkg::ColW-1:0];
    s2_cmd_nxt.y1 = hi_y[csfe_pkg::RowW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
    if (accept1) begin
      s1_kind_r  <= kind;
      s1_x_r     <= 11'(x_pos);
      s1_y_r     <= 11'(y_pos);
      s1_a_r     <= size_a;
      s1_b_r     <= size_b;
      s1_a2_r    <= 16'(size_a) * 16'(size_a);
      s1_b2_r    <= 16'(size_b) * 16'(size_b);
      s1_color_r <= csfe_pkg::pack_color(red & csfe_pkg::RedMask,
                                         green & csfe_pkg::GreenMask, blue);
    end
    if (adv2 && s1_valid_r) s2_cmd_r <= s2_cmd_nxt;
  end

endmodule

@@ rtl/csfe_back.sv @@
// Back end: walks clipped boxes in the store, rectangles one pixel a cycle.
// Depends on csfe_pkg; holds the frame store memory and the result register.
module csfe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  csfe_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [15:0]    pixel_value,
  output logic           on_store
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_TEST = 4'b0100,
    ST_READ = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  csfe_pkg::cmd_t cur_r;
  logic [csfe_pkg::ColW-1:0] col_r, col_nxt;
  logic [csfe_pkg::RowW-1:0] row_r, row_nxt;
  logic [csfe_pkg::AddrW-1:0] addr_r, addr_nxt, rd_addr;
  logic [15:0] mem [csfe_pkg::StoreDepth];
  logic [15:0] rd_data_r;
  logic        rd_on_r;
  logic        res_valid_r, res_valid_nxt;
  logic [7:0]  ax, ay;
  logic [15:0] ax2_r, ay2_r;
  logic [31:0] t1, t2;
  logic        in_box, wr_en, last_col, last_row;
  logic signed [11:0] dx, dy;

  assign cmd_ready   = (state_r == ST_IDLE) && !res_valid_r;
  assign res_valid   = res_valid_r;
  assign pixel_value = rd_on_r ? rd_data_r : 16'd0;
  assign on_store    = rd_on_r;

  assign dx = 12'(col_r) - 12'(cur_r.cx);
  assign dy = 12'(row_r) - 12'(cur_r.cy);
  assign ax = dx[11] ? 8'(-dx) : 8'(dx);
  assign ay = dy[11] ? 8'(-dy) : 8'(dy);
  assign t1 = 32'(ax2_r) * 32'(cur_r.wx);
  assign t2 = 32'(ay2_r) * 32'(cur_r.wy);
  assign in_box  = (col_r < cur_r.x1) && (row_r < cur_r.y1);
  assign last_col = (col_r + 1'b1) >= cur_r.x1;
  assign last_row = (row_r + 1'b1) >= cur_r.y1;
  assign rd_addr  = csfe_pkg::AddrW'(cmd.y0 * csfe_pkg::StoreWidth) +
                    csfe_pkg::AddrW'(cmd.x0);

  always_comb begin
    state_nxt = state_r;
    col_nxt = col_r;
    row_nxt = row_r;
    addr_nxt = addr_r;
    wr_en = 1'b0;
    res_valid_nxt = res_valid_r && !res_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          col_nxt = cmd.x0;
          row_nxt = cmd.y0;
          addr_nxt = rd_addr;
          unique case (cmd.op)
            csfe_pkg::OP_READ:  state_nxt = ST_READ;
            csfe_pkg::OP_CLEAR: begin
              col_nxt = '0;
              row_nxt = '0;
              addr_nxt = '0;
              state_nxt = ST_WALK;
            end
            default: state_nxt = ST_WALK;
          endcase
        end
      end
      ST_WALK: begin
        if (!in_box) state_nxt = ST_IDLE;
        else if (cur_r.shaped) state_nxt = ST_TEST;
        else begin
          wr_en = 1'b1;
          if (last_col) begin
            col_nxt = cur_r.x0;
            row_nxt = row_r + 1'b1;
            addr_nxt = addr_r + csfe_pkg::AddrW'(csfe_pkg::StoreWidth) + 1'b1
                       - csfe_pkg::AddrW'(cur_r.x1 - cur_r.x0);
            if (last_row) state_nxt = ST_IDLE;
          end else begin
            col_nxt = col_r + 1'b1;
            addr_nxt = addr_r + 1'b1;
          end
        end
      end
      ST_TEST: begin
        wr_en = (33'(t1) + 33'(t2)) <= 33'(cur_r.lim);
        state_nxt = ST_WALK;
        if (last_col) begin
          col_nxt = cur_r.x0;
          row_nxt = row_r + 1'b1;
          addr_nxt = addr_r + csfe_pkg::AddrW'(csfe_pkg::StoreWidth) + 1'b1
                     - csfe_pkg::AddrW'(cur_r.x1 - cur_r.x0);
          if (last_row) state_nxt = ST_IDLE;
        end else begin
          col_nxt = col_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_READ: begin
        res_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    addr_r <= addr_nxt;
    ax2_r  <= 16'(ax) * 16'(ax);
    ay2_r  <= 16'(ay) * 16'(ay);
    if (cmd_valid && cmd_ready) begin
      cur_r <= cmd;
      if (cmd.op == csfe_pkg::OP_CLEAR) begin
        cur_r.x0 <= '0;
        cur_r.y0 <= '0;
        cur_r.x1 <= csfe_pkg::ColW'(csfe_pkg::StoreWidth);
        cur_r.y1 <= csfe_pkg::RowW'(csfe_pkg::StoreHeight);
        cur_r.shaped <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr_r] <= cur_r.color;
    if (state_r == ST_READ) begin
      rd_data_r <= mem[addr_r];
      rd_on_r   <= cur_r.on_store;
    end
  end

endmodule

@@ rtl/clipped_shape_fill_engine_unit.sv @@
// Top level of the clipped shape fill engine: front end, command queue, back end.
// Depends on csfe_pkg, csfe_front and csfe_back.
//
// Drawing commands fill a 240 by 135 store of byte-swapped RGB565 pixels. A rectangle,
// circle or ellipse walks its clipped bounding box; a circle or ellipse takes each pixel
// through a walk state and then a test state (square, then weighted compare). A clear
// walks the whole store. A read word is registered in the read state, then offered.
// A four-word queue lets new commands be taken while a fill is still running.
module clipped_shape_fill_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // kind, x_pos, y_pos, size_a, size_b, red, green, blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata  // pixel_value, on_store
);

  logic           f_valid, f_ready, b_valid, b_ready;
  csfe_pkg::cmd_t f_cmd;
  csfe_pkg::cmd_t q_mem_r [csfe_pkg::QueueDepth];
  logic [csfe_pkg::QueuePtrW-1:0] wp_r, rp_r;
  logic [csfe_pkg::QueuePtrW:0]   cnt_r;
  logic [15:0] pix;
  logic        ons;

  csfe_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .kind(in_tdata[2:0]), .x_pos(in_tdata[12:3]), .y_pos(in_tdata[22:13]),
    .size_a(in_tdata[30:23]), .size_b(in_tdata[38:31]),
    .red(in_tdata[46:39]), .green(in_tdata[54:47]), .blue(in_tdata[62:55]),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  assign f_ready = cnt_r != (csfe_pkg::QueuePtrW+1)'(csfe_pkg::QueueDepth);
  assign b_valid = cnt_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (f_valid && f_ready) wp_r <= wp_r + 1'b1;
      if (b_valid && b_ready) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (csfe_pkg::QueuePtrW+1)'(f_valid && f_ready)
                     - (csfe_pkg::QueuePtrW+1)'(b_valid && b_ready);
    end
    if (f_valid && f_ready) q_mem_r[wp_r] <= f_cmd;
  end

  csfe_back u_back (
    .clk, .rst_n,
    .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(q_mem_r[rp_r]),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .pixel_value(pix), .on_store(ons)
  );

  assign out_tdata = {7'd0, ons, pix};

endmodule
